@@ rtl/cmbi_pkg.sv @@
// Shared types, codes and constants for the cartridge mapper bank/IRQ unit.
// No dependencies; every module of the block imports this package.
package cmbi_pkg;

   // Command queue between the decode front and the result back
   localparam int QDepth = 2;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   // Input item kinds (req_tuser)
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   // Result kinds (rsp_tuser)
   localparam logic [2:0] KIND_NONE   = 3'd0;
   localparam logic [2:0] KIND_PRG    = 3'd1;
   localparam logic [2:0] KIND_CHR    = 3'd2;
   localparam logic [2:0] KIND_MIRROR = 3'd3;
   localparam logic [2:0] KIND_IRQ    = 3'd4;

   // Program window numbers
   localparam logic [2:0] SLOT_PRG_LO = 3'd4;
   localparam logic [2:0] SLOT_PRG_HI = 3'd5;
   localparam logic [2:0] SLOT_PRG_C  = 3'd6;

   // Register addresses
   localparam logic [15:0] ADDR_PRG_PAIR = 16'h8000;
   localparam logic [15:0] ADDR_MIRROR   = 16'hB003;
   localparam logic [15:0] ADDR_PRG_C    = 16'hC000;
   localparam logic [15:0] ADDR_CHR_LO   = 16'hD000;
   localparam logic [15:0] ADDR_CHR_HI   = 16'hE000;
   localparam logic [15:0] ADDR_IRQ_LAT  = 16'hF000;
   localparam logic [15:0] ADDR_IRQ_EN   = 16'hF001;
   localparam logic [15:0] ADDR_IRQ_CTRL = 16'hF002;

   // Counter value at and above which a tick fires the IRQ
   localparam logic [7:0] IrqWrap = 8'hFE;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] slot;
      logic [8:0] bank;
      logic [3:0] mirror_map;
      logic       pair;        // program pair: back emits windows 4 and 5
   } cmbi_cmd_type;

   typedef struct packed {
      logic can_push;
      logic has_data;
   } cmbi_qstat_type;

   // Pattern register index to 1K window
   function automatic logic [2:0] pattern_slot(input logic [2:0] idx);
      logic [2:0] slot;
      case (idx)
         3'd0: slot = 3'd0;
         3'd1: slot = 3'd2;
         3'd2: slot = 3'd1;
         3'd3: slot = 3'd3;
         3'd4: slot = 3'd4;
         3'd5: slot = 3'd6;
         3'd6: slot = 3'd5;
         3'd7: slot = 3'd7;
         default: slot = 3'd0;
      endcase
      return slot;
   endfunction

endpackage

@@ rtl/cmbi_front.sv @@
// Decode front: accepts CPU writes and scanline ticks, owns the IRQ state,
// classifies each item into one queued command. Depends on cmbi_pkg.
module cmbi_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [23:0]             req_tdata,   // [15:0] address, [23:16] data
   input  logic                    req_tuser,   // [0] mode
   input  cmbi_pkg::cmbi_qstat_type qstat,
   output logic                    push,
   output cmbi_pkg::cmbi_cmd_type  cmd
);
   import cmbi_pkg::*;

   localparam logic [6:0] MIR_ONE_A = 7'h08;
   localparam logic [6:0] MIR_ONE_B = 7'h2C;
   localparam logic [6:0] MIR_VERT  = 7'h20;
   localparam logic [6:0] MIR_HORZ  = 7'h24;
   localparam logic [6:0] MIR_ZERO  = 7'h28;

   localparam logic [3:0] MAP_ONE  = 4'hF;
   localparam logic [3:0] MAP_VERT = 4'hA;
   localparam logic [3:0] MAP_HORZ = 4'hC;
   localparam logic [3:0] MAP_ZERO = 4'h0;

   logic [1:0]  irq_en_ff, irq_en_in;
   logic [7:0]  irq_count_ff, irq_count_in;
   logic [7:0]  irq_reload_ff, irq_reload_in;
   logic [15:0] addr;
   logic [7:0]  data;
   logic [6:0]  mcode;
   logic        accept;

   assign req_tready = qstat.can_push;
   assign accept     = req_tvalid & qstat.can_push;
   assign push       = accept;

   always_comb begin
      addr          = req_tdata[15:0];
      data          = req_tdata[23:16];
      mcode         = data[6:0];
      cmd           = '0;
      cmd.kind      = KIND_NONE;
      irq_en_in     = irq_en_ff;
      irq_count_in  = irq_count_ff;
      irq_reload_in = irq_reload_ff;
      if (req_tuser == MODE_TICK) begin
         if (irq_en_ff != 2'b00) begin
            if (irq_count_ff >= IrqWrap) begin
               irq_count_in = irq_reload_ff;
               irq_en_in    = 2'b00;
               cmd.kind     = KIND_IRQ;
            end else begin
               irq_count_in = irq_count_ff + 8'd1;
            end
         end
      end else begin
         if (addr == ADDR_PRG_PAIR) begin
            cmd.kind = KIND_PRG;
            cmd.slot = SLOT_PRG_LO;
            cmd.bank = {data, 1'b0};
            cmd.pair = 1'b1;
         end else if (addr == ADDR_PRG_C) begin
            cmd.kind = KIND_PRG;
            cmd.slot = SLOT_PRG_C;
            cmd.bank = {1'b0, data};
         end else if (addr[15:2] == ADDR_CHR_LO[15:2] || addr[15:2] == ADDR_CHR_HI[15:2]) begin
            // 0xD000-0xD003 select the low four windows, 0xE000-0xE003 the high four
            cmd.kind = KIND_CHR;
            cmd.slot = pattern_slot({~addr[12], addr[1:0]});
            cmd.bank = {1'b0, data};
         end else if (addr == ADDR_MIRROR) begin
            case (mcode)
               MIR_ONE_A, MIR_ONE_B: begin
                  cmd.kind       = KIND_MIRROR;
                  cmd.mirror_map = MAP_ONE;
               end
               MIR_VERT: begin
                  cmd.kind       = KIND_MIRROR;
                  cmd.mirror_map = MAP_VERT;
               end
               MIR_HORZ: begin
                  cmd.kind       = KIND_MIRROR;
                  cmd.mirror_map = MAP_HORZ;
               end
               MIR_ZERO: begin
                  cmd.kind       = KIND_MIRROR;
                  cmd.mirror_map = MAP_ZERO;
               end
               default: ;
            endcase
         end else if (addr == ADDR_IRQ_LAT) begin
            irq_reload_in = data;
         end else if (addr == ADDR_IRQ_EN) begin
            irq_en_in = {1'b0, data[0]};
         end else if (addr == ADDR_IRQ_CTRL) begin
            irq_en_in = data[1:0];
            if (data[1]) begin
               irq_count_in = irq_reload_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_en_ff     <= 2'b00;
         irq_count_ff  <= 8'd0;
         irq_reload_ff <= 8'd0;
      end else if (accept) begin
         irq_en_ff     <= irq_en_in;
         irq_count_ff  <= irq_count_in;
         irq_reload_ff <= irq_reload_in;
      end
   end

`ifndef SYNTHESIS
   a_irq_disarms: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == MODE_TICK && irq_en_ff != 2'b00 && irq_count_ff >= IrqWrap)
      |=> (irq_en_ff == 2'b00 && irq_count_ff == $past(irq_reload_ff)))
      else $error("IRQ fire did not reload and disable the counter");
`endif

endmodule

@@ rtl/cmbi_queue.sv @@
// Short command queue between decode front and result back.
// Depends on cmbi_pkg for the command type and depth.
module cmbi_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cmbi_pkg::cmbi_cmd_type   push_cmd,
   input  logic                     pop,
   output cmbi_pkg::cmbi_qstat_type qstat,
   output cmbi_pkg::cmbi_cmd_type   head
);
   import cmbi_pkg::*;

   cmbi_cmd_type     entry_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCntW-1:0] count_ff, count_in;

   assign qstat.can_push = (count_ff != QCntW'(QDepth));
   assign qstat.has_data = (count_ff != '0);
   assign head           = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_ff + QPtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_ff + QPtrW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != QCntW'(QDepth)))
      else $error("push into a full command queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from an empty command queue");
`endif

endmodule

@@ rtl/cmbi_back.sv @@
// Result back: drains queued commands into the registered result channel,
// splitting a program pair into two transfers. Depends on cmbi_pkg.
module cmbi_back (
   input  logic                     clock,
   input  logic                     reset,
   input  cmbi_pkg::cmbi_qstat_type qstat,
   input  cmbi_pkg::cmbi_cmd_type   head,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,   // [2:0] slot, [11:3] bank, [15:12] mirror_map
   output logic [2:0]               rsp_tuser,   // [2:0] kind
   output logic                     rsp_tlast    // last
);
   import cmbi_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       phase_ff, phase_in;
   logic [2:0] kind_ff, kind_in;
   logic [2:0] slot_ff, slot_in;
   logic [8:0] bank_ff, bank_in;
   logic [3:0] mirror_ff, mirror_in;
   logic       last_ff, last_in;
   logic       load;

   assign load = (!out_valid_ff || rsp_tready) && qstat.has_data;

   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_tready;
      phase_in     = phase_ff;
      pop          = 1'b0;
      kind_in      = kind_ff;
      slot_in      = slot_ff;
      bank_in      = bank_ff;
      mirror_in    = mirror_ff;
      last_in      = last_ff;
      if (load) begin
         out_valid_in = 1'b1;
         kind_in      = head.kind;
         slot_in      = head.slot;
         bank_in      = head.bank;
         mirror_in    = head.mirror_map;
         last_in      = 1'b1;
         if (head.pair && !phase_ff) begin
            // first half of a program pair: keep the command at the head
            last_in  = 1'b0;
            phase_in = 1'b1;
         end else if (head.pair) begin
            slot_in  = SLOT_PRG_HI;
            bank_in  = {head.bank[8:1], 1'b1};
            phase_in = 1'b0;
            pop      = 1'b1;
         end else begin
            pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      slot_ff   <= slot_in;
      bank_ff   <= bank_in;
      mirror_ff <= mirror_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {mirror_ff, bank_ff, slot_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

`ifndef SYNTHESIS
   a_phase_on_pair: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (qstat.has_data && head.pair))
      else $error("second half pending without a program pair at the queue head");
   a_split_only_prg: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !last_ff) |-> (kind_ff == KIND_PRG && slot_ff == SLOT_PRG_LO))
      else $error("non-final result other than the first program window");
`endif

endmodule

@@ rtl/cartridge_mapper_bank_irq_unit.sv @@
// Top level of the cartridge mapper bank and scanline IRQ unit.
// Depends on cmbi_pkg, cmbi_front, cmbi_queue and cmbi_back.
//
// Usage:
//   req channel: one item per transfer. req_tuser is the mode (0 = CPU write,
//   1 = scanline tick); req_tdata carries the exact write address and data.
//   rsp channel: one or two result transfers per item. rsp_tuser is the
//   event kind, rsp_tdata the window, bank and mirroring map, rsp_tlast
//   marks the final result of an item. A write to 0x8000 yields two
//   transfers (program windows 4 and 5); every other item yields one,
//   of kind none when it causes no event.
//   An accepted item goes through the command queue into the result register.
//   Throughput: one item per cycle sustained while rsp_tready stays high and
//   no program pair is split; a two-result item holds the result register for
//   both transfers. A two-entry command queue parts the decode front and the
//   result register, so an item is taken while a finished result still waits
//   on rsp_tready. When the receiver stalls, the result holds and the queue
//   fills; req_tready drops only once both queue entries are occupied.
//   Reset clears the IRQ enable bits, counter and latch, empties the queue
//   and drops any pending result.
module cartridge_mapper_bank_irq_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] address, [23:16] data
   input  logic        req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] slot, [11:3] bank, [15:12] mirror_map
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast    // last
);
   import cmbi_pkg::*;

   cmbi_qstat_type qstat;
   cmbi_cmd_type   push_cmd;
   cmbi_cmd_type   head;
   logic           push;
   logic           pop;

   // Decode and IRQ bookkeeping happen at the accepting edge
   cmbi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .qstat      (qstat),
      .push       (push),
      .cmd        (push_cmd)
   );

   // Absorb result-side stalls
   cmbi_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .qstat    (qstat),
      .head     (head)
   );

   // Expand commands into result transfers
   cmbi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
